/* src/lsp_pkg.sv */
// Shared types and constants for the LED strip pattern generator.
// No dependencies; imported by every module of the block but lsp_ram.
`timescale 1ns / 1ps

package lsp_pkg;

    // Pattern modes, as held in the mode register
    localparam logic [1:0] MODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_FIXED   = 2'd1;
    localparam logic [1:0] MODE_RAINBOW = 2'd2;
    localparam logic [1:0] MODE_BAD     = 2'd3;

    // Register indexes on the configuration port (byte address / 4)
    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_BRIGHT   = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;

    // Input transaction kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Rainbow hue phases
    localparam logic [1:0] PHASE_RED   = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_BLUE  = 2'd2;

    localparam logic [7:0]  LEVEL_STEP     = 8'd2;
    localparam logic [7:0]  LEVEL_TOP      = 8'd253;
    localparam logic [7:0]  BRIGHT_RESET   = 8'd128;
    localparam logic [15:0] INTERVAL_RESET = 16'd20;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_STEP,
        ST_READ,
        ST_SCALE,
        ST_OUT
    } t_state;

    // Request to the shared channel scaler
    typedef struct packed {
        logic       en;
        logic [7:0] chan;
    } t_scale_req;

endpackage

/* src/lsp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lsp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* src/lsp_scale_unit.sv */
// Shared channel scaler: channel * brightness / 255, truncated.
// Depends on lsp_pkg for the request struct.
`timescale 1ns / 1ps

module lsp_scale_unit import lsp_pkg::*; (
    input  logic       i_clk,
    input  t_scale_req i_req,
    input  logic [7:0] i_bright,
    output logic [7:0] o_quot
);

    logic [15:0] r_prod;
    logic [15:0] w_sum;

    // register the product, then divide by 255 through the 257/65536 identity
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= {8'd0, i_req.chan} * {8'd0, i_bright};
        end
    end

    assign w_sum  = r_prod + 16'd1 + {8'd0, r_prod[15:8]};
    assign o_quot = w_sum[15:8];

endmodule

/* src/led_strip_pattern_generator_top.sv */
// Top level of the LED strip pattern generator: sequencer, registers, stream ports.
// Depends on lsp_pkg, lsp_ram and lsp_scale_unit.
`timescale 1ns / 1ps

// The block takes one input transaction at a time on the slave stream: either a
// millisecond tick (tuser low) or a colour map write (tuser high). A map write
// leaves the block idle, so map writes can follow each other back to back. A
// tick that brings no frame returns to idle after its evaluation; when the
// configured interval has elapsed (and, in fixed mode, a refresh is pending
// after reset, a map write or a mode write) it starts a frame of LED_COUNT GRB
// pixels on the master stream, and the block stays busy (s_axis_tready low)
// until the frame's last pixel, marked by tlast, has been taken. Each pixel
// goes through the colour map read, the shared scaler (one multiplier, each
// of the three channels in turn) and the pixel handshake, which waits out any
// output stall; in rainbow mode a frame first steps the rainbow levels. The
// colour map lives in a small RAM with a valid bit per entry, so it reads as
// zero after reset without any clearing pass. Configuration must be written
// through the APB-style port while the block is idle; the block does not check.
module led_strip_pattern_generator_top import lsp_pkg::*; #(
    parameter int LED_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [5:0] led_index, [29:6] map_color, [31:30] zero
    input  logic        s_axis_tuser,   // [0] kind
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [23:0] pixel_word
    output logic        m_axis_tlast,   // last_pixel
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    // registers
    t_state             r_state, n_state;
    logic [1:0]         r_mode;
    logic [7:0]         r_bright;
    logic [15:0]        r_interval;
    logic [15:0]        r_elapsed;
    logic [1:0]         r_phase;
    logic [7:0]         r_red, r_green, r_blue;
    logic               r_refresh;
    logic [LED_COUNT-1:0] r_map_valid;
    logic               r_rd_valid;
    logic [IDX_W-1:0]   r_led;
    logic [1:0]         r_ch;
    logic [23:0]        r_pixel;

    // decode
    logic               w_in_acc;
    logic               w_cfg_wr;
    logic [5:0]         w_in_idx;
    logic [23:0]        w_in_color;
    logic               w_map_we;
    logic [15:0]        w_ival;
    logic               w_due;
    logic               w_last_led;
    logic [23:0]        w_src;
    logic [23:0]        w_ram_rdata;
    logic [7:0]         w_quot;
    t_scale_req         w_req;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_in_idx   = s_axis_tdata[5:0];
    assign w_in_color = s_axis_tdata[29:6];
    // drop map writes that fall beyond the strip
    assign w_map_we   = w_in_acc && (s_axis_tuser == KIND_WRITE)
                        && ({1'b0, w_in_idx} < 7'(LED_COUNT));
    // a zero interval behaves as one tick
    assign w_ival     = (r_interval == 16'd0) ? 16'd1 : r_interval;
    assign w_due      = (r_elapsed >= w_ival);
    assign w_last_led = (r_led == IDX_W'(LED_COUNT - 1));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = r_pixel;
    assign m_axis_tlast  = w_last_led;
    assign pready        = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_MODE:     prdata = {30'd0, r_mode};
            REG_BRIGHT:   prdata = {24'd0, r_bright};
            REG_INTERVAL: prdata = {16'd0, r_interval};
            default:      prdata = 32'd0;
        endcase
    end

    // colour map storage; the read address follows the pixel counter
    lsp_ram #(
        .WIDTH (24),
        .DEPTH (LED_COUNT)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (w_in_idx[IDX_W-1:0]),
        .i_wdata (w_in_color),
        .i_raddr (r_led),
        .o_rdata (w_ram_rdata)
    );

    // pixel source: map entry (zero until written), solid rainbow colour or black
    always_comb begin
        case (r_mode)
            MODE_FIXED:   w_src = r_rd_valid ? w_ram_rdata : 24'd0;
            MODE_RAINBOW: w_src = {r_green, r_red, r_blue};
            default:      w_src = 24'd0;
        endcase
    end

    // feed green, red, blue in turn; each quotient comes in the cycle after its request
    always_comb begin
        w_req.en = (r_state == ST_SCALE) && (r_ch != 2'd3);
        case (r_ch)
            2'd0:    w_req.chan = w_src[23:16];
            2'd1:    w_req.chan = w_src[15:8];
            default: w_req.chan = w_src[7:0];
        endcase
    end

    lsp_scale_unit u_scale (
        .i_clk    (i_clk),
        .i_req    (w_req),
        .i_bright (r_bright),
        .o_quot   (w_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (s_axis_tuser == KIND_TICK) ? ST_EVAL : ST_IDLE;
                end
            end
            ST_EVAL: begin
                if (!w_due) begin
                    n_state = ST_IDLE;
                end else begin
                    case (r_mode)
                        MODE_FIXED:   n_state = r_refresh ? ST_READ : ST_IDLE;
                        MODE_RAINBOW: n_state = ST_STEP;
                        default:      n_state = ST_READ;
                    endcase
                end
            end
            ST_STEP:  n_state = ST_READ;
            ST_READ:  n_state = ST_SCALE;
            ST_SCALE: n_state = (r_ch == 2'd3) ? ST_OUT : ST_SCALE;
            ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = w_last_led ? ST_IDLE : ST_READ;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration, counters and rainbow levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_OFF;
            r_bright    <= BRIGHT_RESET;
            r_interval  <= INTERVAL_RESET;
            r_elapsed   <= 16'd0;
            r_phase     <= PHASE_RED;
            r_red       <= 8'd0;
            r_green     <= 8'd0;
            r_blue      <= 8'd0;
            r_refresh   <= 1'b1;
            r_map_valid <= '0;
            r_led       <= '0;
            r_ch        <= 2'd0;
        end else begin
            // hold the count at its top rather than wrap
            if (w_in_acc && (s_axis_tuser == KIND_TICK) && (r_elapsed != COUNT_MAX)) begin
                r_elapsed <= r_elapsed + 16'd1;
            end

            if (r_state == ST_EVAL && w_due) begin
                r_elapsed <= r_elapsed - w_ival;
                if (r_mode == MODE_FIXED) begin
                    r_refresh <= 1'b0;
                end
            end

            if (r_state == ST_STEP) begin
                case (r_phase)
                    PHASE_RED: begin
                        r_blue <= (r_blue >= LEVEL_STEP) ? r_blue - LEVEL_STEP : 8'd0;
                        if (r_red >= LEVEL_TOP) r_phase <= PHASE_GREEN;
                        else                    r_red   <= r_red + LEVEL_STEP;
                    end
                    PHASE_GREEN: begin
                        r_red <= (r_red >= LEVEL_STEP) ? r_red - LEVEL_STEP : 8'd0;
                        if (r_green >= LEVEL_TOP) r_phase <= PHASE_BLUE;
                        else                      r_green <= r_green + LEVEL_STEP;
                    end
                    PHASE_BLUE: begin
                        r_green <= (r_green >= LEVEL_STEP) ? r_green - LEVEL_STEP : 8'd0;
                        if (r_blue >= LEVEL_TOP) r_phase <= PHASE_RED;
                        else                     r_blue  <= r_blue + LEVEL_STEP;
                    end
                    default: r_phase <= PHASE_RED;
                endcase
            end

            // pixel and channel counters
            if (r_state == ST_EVAL) begin
                r_led <= '0;
            end
            if (r_state == ST_READ) begin
                r_ch <= 2'd0;
            end else if (r_state == ST_SCALE) begin
                r_ch <= r_ch + 2'd1;
            end
            if (r_state == ST_OUT && m_axis_tready && !w_last_led) begin
                r_led <= r_led + IDX_W'(1);
            end

            // mark refresh last so that it wins over a clear
            if (w_map_we) begin
                r_map_valid[w_in_idx[IDX_W-1:0]] <= 1'b1;
                r_refresh <= 1'b1;
            end

            if (w_cfg_wr) begin
                case (paddr[3:2])
                    REG_MODE: begin
                        if (pwdata[1:0] != MODE_BAD) begin
                            r_mode    <= pwdata[1:0];
                            r_refresh <= 1'b1;
                        end
                    end
                    REG_BRIGHT:   r_bright   <= pwdata[7:0];
                    REG_INTERVAL: r_interval <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    // payload: valid flag alongside the map read, pixel assembled channel by channel
    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_map_valid[r_led];
        if (r_state == ST_SCALE && r_ch != 2'd0) begin
            r_pixel <= {r_pixel[15:0], w_quot};
        end
    end

endmodule

/* src/lsp_checker.sv */
// Port-level checks for the LED strip pattern generator, bound to the top level.
// Depends on lsp_pkg and led_strip_pattern_generator_top.
`timescale 1ns / 1ps

module lsp_checker import lsp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // an accepted tick always keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_TICK)) |=> !s_axis_tready)
        else $error("input ready straight after an accepted tick");

    // never take input while a pixel is on offer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input ready while a pixel is pending");

    // a frame ends with its last pixel
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("pixel offered after the last pixel of a frame");

    // a stalled pixel holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled pixel changed or dropped");

endmodule

bind led_strip_pattern_generator_top lsp_checker u_lsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* tb/led_strip_pattern_generator_top_tb.sv */
// Self-checking testbench for led_strip_pattern_generator_top: ticks and map writes go in,
// pixel frames come out and are checked against a predictor of the strip state.
// Depends on lsp_pkg and the RTL of the block; needs nothing else.
`timescale 1ns / 1ps

module led_strip_pattern_generator_top_tb;
    import lsp_pkg::*;

    localparam int STRIP_LEN   = 16;
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the block up
    localparam int SWEEP_TICKS = 60;    // long run of rainbow frames with no idling
    localparam int RAND_PHASES = 4;
    localparam int RAND_ITEMS  = 12;    // per random phase

    // Register index with no register behind it; writes there must change nothing
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic        kind;
        logic [5:0]  idx;
        logic [23:0] colour;
    } t_strip_item;

    typedef struct {
        logic [23:0] grb;
        logic        is_last;
    } t_pixel;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports; every input known from time 0
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [5:0] led_index, [29:6] map_color, [31:30] zero
    logic        s_axis_tuser = 1'b0;   // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [23:0] pixel_word
    logic        m_axis_tlast;          // last_pixel
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    led_strip_pattern_generator_top #(
        .LED_COUNT(STRIP_LEN)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: a copy of the block's registers and pattern state
    // ------------------------------------------------------------------
    logic [1:0]  strip_mode = MODE_OFF;
    logic [7:0]  strip_bright = BRIGHT_RESET;
    logic [15:0] strip_interval = INTERVAL_RESET;
    logic [15:0] tick_count = '0;
    logic [1:0]  hue = PHASE_RED;
    logic [7:0]  red_lvl = '0;
    logic [7:0]  green_lvl = '0;
    logic [7:0]  blue_lvl = '0;
    logic        refresh_due = 1'b1;
    logic [23:0] colour_map [STRIP_LEN];

    initial foreach (colour_map[i]) colour_map[i] = '0;

    t_strip_item items_to_send[$];   // waiting for the driver
    t_pixel      pixels_due[$];      // predicted pixels not yet seen

    t_strip_item next_item;
    t_pixel      want;
    logic        in_fire = 1'b0;     // input transaction taken at the last rising edge
    int          idle_pct = 15;
    int          holds_asked = 0;
    int          holds_served = 0;
    int          hold_left = 0;
    int          mismatches = 0;
    int          ticks_sent = 0;
    int          writes_sent = 0;
    int          pixels_seen = 0;
    int          frames_seen = 0;
    int          settings_used = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] dim_chan(input logic [7:0] ch);
        return 8'((int'(ch) * int'(strip_bright)) / 255);
    endfunction

    function automatic logic [23:0] dim_grb(input logic [23:0] c);
        return {dim_chan(c[23:16]), dim_chan(c[15:8]), dim_chan(c[7:0])};
    endfunction

    function automatic logic [7:0] level_down(input logic [7:0] lv);
        return (lv >= LEVEL_STEP) ? lv - LEVEL_STEP : 8'd0;
    endfunction

    // One step of the three-phase colour cycle: one level falls, the next rises
    // until it tops out, and then the phase moves on.
    task automatic step_hue();
        case (hue)
            PHASE_RED: begin
                blue_lvl = level_down(blue_lvl);
                if (red_lvl >= LEVEL_TOP) hue = PHASE_GREEN;
                else red_lvl = red_lvl + LEVEL_STEP;
            end
            PHASE_GREEN: begin
                red_lvl = level_down(red_lvl);
                if (green_lvl >= LEVEL_TOP) hue = PHASE_BLUE;
                else green_lvl = green_lvl + LEVEL_STEP;
            end
            PHASE_BLUE: begin
                green_lvl = level_down(green_lvl);
                if (blue_lvl >= LEVEL_TOP) hue = PHASE_RED;
                else blue_lvl = blue_lvl + LEVEL_STEP;
            end
            default: hue = PHASE_RED;
        endcase
    endtask

    // Work out what one accepted input transaction does to the strip and queue
    // the pixels of any frame that falls due.
    task automatic advance_strip(input logic kind, input logic [5:0] idx,
                                 input logic [23:0] colour);
        logic [15:0] span;
        logic [23:0] solid;
        t_pixel      px;
        if (kind == KIND_WRITE) begin
            // entries past the end of the strip are dropped without a refresh
            if (int'(idx) < STRIP_LEN) begin
                colour_map[idx] = colour;
                refresh_due = 1'b1;
            end
            return;
        end
        span = (strip_interval == 16'd0) ? 16'd1 : strip_interval;
        if (tick_count != COUNT_MAX) tick_count = tick_count + 16'd1;
        if (tick_count < span) return;
        tick_count = tick_count - span;
        solid = '0;
        if (strip_mode == MODE_FIXED) begin
            // fixed map goes out only once per refresh
            if (!refresh_due) return;
            refresh_due = 1'b0;
        end else if (strip_mode == MODE_RAINBOW) begin
            step_hue();
            solid = dim_grb({green_lvl, red_lvl, blue_lvl});
        end
        for (int i = 0; i < STRIP_LEN; i++) begin
            px.grb = (strip_mode == MODE_FIXED) ? dim_grb(colour_map[i]) : solid;
            px.is_last = (i == STRIP_LEN - 1);
            pixels_due.push_back(px);
        end
    endtask

    // ------------------------------------------------------------------
    // Configuration writes: setup cycle, then access cycle; the predictor is
    // updated alongside, which is safe as writes happen only while idle
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_MODE: begin
                // the unused mode code is refused and marks nothing
                if (value[1:0] != MODE_BAD) begin
                    strip_mode  = value[1:0];
                    refresh_due = 1'b1;
                end
            end
            REG_BRIGHT:   strip_bright = value[7:0];
            REG_INTERVAL: strip_interval = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_item(input logic kind, input logic [5:0] idx,
                              input logic [23:0] colour);
        t_strip_item it;
        it.kind   = kind;
        it.idx    = idx;
        it.colour = colour;
        items_to_send.push_back(it);
    endtask

    // Random content; a third are map writes, a quarter of those out of range
    task automatic queue_random_item();
        logic        kind;
        logic [5:0]  idx;
        kind = ($urandom_range(0, 99) < 35) ? KIND_WRITE : KIND_TICK;
        idx  = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, STRIP_LEN - 1))
                                           : 6'($urandom_range(STRIP_LEN, 63));
        queue_item(kind, idx, 24'($urandom));
    endtask

    // Hold until every item has gone in and every predicted pixel has come out,
    // then let a map write or a frameless tick finish inside the block.
    task automatic wait_idle();
        while (items_to_send.size() != 0 || s_axis_tvalid || pixels_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the next pending item once the current one is taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || in_fire) begin
            if (items_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                next_item = items_to_send.pop_front();
                s_axis_tdata  <= {2'b00, next_item.colour, next_item.idx};
                s_axis_tuser  <= next_item.kind;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (holds_asked != holds_served) begin
            holds_served = holds_served + 1;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check pixels against the oldest prediction, then predict from
    // any input transaction taken at this edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            pixels_seen++;
            if (m_axis_tlast) frames_seen++;
            if (pixels_due.size() == 0) begin
                $display("%0t: unexpected pixel grb %06h last %b", $time,
                         m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                want = pixels_due.pop_front();
                if (m_axis_tdata !== want.grb) begin
                    $display("%0t: pixel_word expected %06h actual %06h", $time,
                             want.grb, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== want.is_last) begin
                    $display("%0t: last_pixel expected %b actual %b", $time,
                             want.is_last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            if (s_axis_tuser == KIND_WRITE) writes_sent++;
            else ticks_sent++;
            advance_strip(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[29:6]);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero interval acts as one, so every tick brings a frame; mode off
        // gives dark pixels. Map writes at both ends and past the strip.
        write_reg(REG_INTERVAL, 32'd0);
        write_reg(REG_BRIGHT, 32'd255);
        write_reg(REG_MODE, {30'd0, MODE_OFF});
        settings_used++;
        queue_item(KIND_TICK, 6'd0, 24'h000000);
        queue_item(KIND_WRITE, 6'd0, 24'hFFFFFF);
        queue_item(KIND_WRITE, 6'd15, 24'h000000);
        queue_item(KIND_WRITE, 6'd63, 24'hFFFFFF);
        queue_item(KIND_WRITE, 6'd16, 24'h123456);
        wait_idle();

        // Fixed map: first tick sends it, the second has nothing to refresh,
        // a map write re-arms it.
        write_reg(REG_MODE, {30'd0, MODE_FIXED});
        settings_used++;
        queue_item(KIND_TICK, 6'd0, 24'h000000);
        queue_item(KIND_TICK, 6'd0, 24'h000000);
        queue_item(KIND_WRITE, 6'd7, 24'hA5C3F0);
        queue_item(KIND_TICK, 6'd63, 24'hFFFFFF);
        wait_idle();

        // Unused mode code and spare register: nothing changes, no refresh
        write_reg(REG_MODE, {30'd0, MODE_BAD});
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        queue_item(KIND_TICK, 6'd0, 24'h000000);
        wait_idle();

        // Zero brightness blanks the map
        write_reg(REG_BRIGHT, 32'd0);
        write_reg(REG_MODE, {30'd0, MODE_FIXED});
        settings_used++;
        queue_item(KIND_TICK, 6'd0, 24'h000000);
        wait_idle();

        // Longest interval builds up a count, then a short one works it off
        write_reg(REG_BRIGHT, 32'd128);
        write_reg(REG_INTERVAL, 32'd65535);
        write_reg(REG_MODE, {30'd0, MODE_RAINBOW});
        settings_used++;
        repeat (6) queue_item(KIND_TICK, 6'd0, 24'h000000);
        wait_idle();
        write_reg(REG_INTERVAL, 32'd2);
        settings_used++;
        repeat (6) queue_item(KIND_TICK, 6'd0, 24'h000000);
        wait_idle();

        // Rainbow run at full brightness, a frame on every tick, with no
        // idling on either side
        idle_pct = 0;
        write_reg(REG_BRIGHT, 32'd255);
        write_reg(REG_INTERVAL, 32'd1);
        settings_used++;
        repeat (SWEEP_TICKS) queue_item(KIND_TICK, 6'($urandom), 24'($urandom));
        wait_idle();
        idle_pct = 15;

        // Random phases; the first one stalls the receiver for a long stretch
        // so that a frame backs up and the block stops taking input
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0) begin
                write_reg(REG_INTERVAL, 32'd1);
                write_reg(REG_MODE, {30'd0, MODE_RAINBOW});
            end else begin
                write_reg(REG_INTERVAL, 32'($urandom_range(0, 4)));
                write_reg(REG_MODE, 32'($urandom_range(0, 3)));
            end
            write_reg(REG_BRIGHT, 32'($urandom_range(0, 255)));
            settings_used++;
            repeat (RAND_ITEMS) queue_random_item();
            if (ph == 0) holds_asked++;
            wait_idle();
        end

        repeat (40) @(posedge i_clk);
        if (pixels_due.size() != 0) begin
            $display("%0t: %0d predicted pixels never arrived", $time, pixels_due.size());
            mismatches++;
        end
        $display("Run covered %0d ticks and %0d map writes over %0d register settings,",
                 ticks_sent, writes_sent, settings_used);
        $display("checking %0d pixels in %0d frames; %0d mismatches.",
                 pixels_seen, frames_seen, mismatches);
        if (mismatches == 0) begin
            $display("led_strip_pattern_generator_top verification clean");
        end else begin
            $display("led_strip_pattern_generator_top verification failed");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest correct run
    initial begin
        #1_500_000;
        $display("%0t: timeout with %0d pixels outstanding", $time, pixels_due.size());
        $display("led_strip_pattern_generator_top verification failed");
        $finish;
    end

endmodule
